FILE: rtl/glzw_pkg.sv
// Package for the GIF LZW pixel decoder: payload structs, status and
// register codes, default sizes. No dependencies.
package glzw_pkg;

  localparam int unsigned MaxCodeBitsDef = 12;
  localparam int unsigned TableDepthDef  = 4096;
  localparam int unsigned CfgIdxW        = 2;
  localparam int unsigned CfgDataW       = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_MIN_CODE_SIZE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LINE_WIDTH    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_LINE_COUNT    = 2'd2;

  typedef enum logic [3:0] {
    ST_PIXEL       = 4'd0,
    ST_NEED_BYTE   = 4'd1,
    ST_BYTE_TAKEN  = 4'd2,
    ST_BYTE_REFUSE = 4'd3,
    ST_DONE        = 4'd4,
    ST_EARLY_END   = 4'd5,
    ST_BAD_CODE    = 4'd6,
    ST_CHAIN_LONG  = 4'd7,
    ST_EMPTY_SUB   = 4'd8,
    ST_AFTER_DONE  = 4'd9
  } status_e;

  typedef enum logic [1:0] {
    FIN_RUN  = 2'd0,
    FIN_TERM = 2'd1,
    FIN_DONE = 2'd2,
    FIN_ERR  = 2'd3
  } fin_e;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] stream_byte;
  } in_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] pixel_index;
    logic       end_of_line;
    logic       end_of_image;
  } out_t;

endpackage

FILE: rtl/glzw_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module glzw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/gif_lzw_pixel_decoder.sv
// Top level of the GIF LZW pixel decoder: sequencer, bit unpacker, counters.
// Depends on glzw_pkg and glzw_ram.
//
// channel  | direction | signals                          | moves
// in       | input     | in_valid_i/in_ready_o/in_data_i  | push byte or pull pixel
// out      | output    | out_valid_o/out_ready_i/out_data_o | one result per transaction
// cfg      | input     | cfg_we_i/cfg_idx_i/cfg_data_i    | register write
//
// A push, or a pull that answers need byte or an error, passes execute and finish; a
// pull that pops a stacked pixel adds the pop state. Each code decoded on the way adds
// expand and trace, a trace write-back per chain link traced through the prefix/suffix
// RAM read port, and a fix step when the code names the entry being defined; a clear
// code re-enters execute. A register write or reset reinitializes decoder state before
// the next transaction is taken; dictionary RAMs need no clearing pass.
// A new transaction is taken while the previous result waits on out_ready_i.
module gif_lzw_pixel_decoder_top import glzw_pkg::*; #(
  parameter int unsigned MAX_CODE_BITS = MaxCodeBitsDef,
  parameter int unsigned TABLE_DEPTH   = TableDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AW  = $clog2(TABLE_DEPTH);
  localparam int unsigned NCW = AW + 1;
  localparam int unsigned CW  = MAX_CODE_BITS;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_EXEC     = 8'b0000_0010,
    S_EXPAND   = 8'b0000_0100,
    S_TRACE    = 8'b0000_1000,
    S_TRACE_WB = 8'b0001_0000,
    S_FIX      = 8'b0010_0000,
    S_POP      = 8'b0100_0000,
    S_FINISH   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [3:0]  mcs_q;
  logic [15:0] lw_q, lc_q;
  logic [31:0] total_q;
  logic        rst_pend_q, rst_pend_d;

  // Decoder state
  logic [31:0]    acc_q, acc_d;
  logic [5:0]     bfill_q, bfill_d;
  logic [NCW-1:0] next_q, next_d, vend_q, vend_d;
  logic [3:0]     cwid_q, cwid_d;
  logic [CW:0]    wlim_q, wlim_d;
  logic [CW-1:0]  prev_q, prev_d, c_q, c_d, x_q, x_d;
  logic           prev_ok_q, prev_ok_d, grew_q, grew_d, spec_q, spec_d;
  logic [7:0]     sub_q, sub_d;
  logic [31:0]    pix_q, pix_d;
  logic [15:0]    col_q, col_d;
  fin_e           fin_q, fin_d;
  status_e        err_q, err_d;
  logic [AW:0]    fill_q, fill_d;
  in_t            cmd_q, cmd_d;
  out_t           res_q, res_d;
  out_t           out_q, out_d;
  logic           out_valid_q, out_valid_d;

  // RAM ports
  logic          tab_we, stk_we;
  logic [AW-1:0] tab_waddr, tab_raddr, stk_waddr, stk_raddr;
  logic [CW-1:0] pre_wdata, pre_rdata;
  logic [7:0]    suf_wdata, suf_rdata, stk_wdata, stk_rdata;

  // Derived values
  logic [3:0]     mcs;
  logic [15:0]    lw_eff, lc_eff;
  logic [8:0]     clr;
  logic [31:0]    code_mask;
  logic [CW-1:0]  code;
  logic [NCW-1:0] e_code;
  logic           x_valid, c_valid;
  logic [16:0]    col_inc;

  always_comb begin
    mcs = mcs_q;
    if (mcs_q < 4'd1) begin
      mcs = 4'd1;
    end else if (mcs_q > 4'd8) begin
      mcs = 4'd8;
    end
  end

  assign lw_eff    = (lw_q == 16'd0) ? 16'd1 : lw_q;
  assign lc_eff    = (lc_q == 16'd0) ? 16'd1 : lc_q;
  assign clr       = 9'd1 << mcs;
  assign code_mask = (32'd1 << cwid_q) - 32'd1;
  assign code      = CW'(acc_q & code_mask);
  assign e_code    = next_q - NCW'(2);
  assign x_valid   = ({1'b0, x_q} >= (CW+1)'(clr) + (CW+1)'(2)) &&
                     (NCW'(x_q) < vend_q) && ({1'b0, x_q} < (CW+1)'(TABLE_DEPTH));
  assign c_valid   = ({1'b0, c_q} >= (CW+1)'(clr) + (CW+1)'(2)) &&
                     (NCW'(c_q) < vend_q) && ({1'b0, c_q} < (CW+1)'(TABLE_DEPTH));
  assign col_inc   = {1'b0, col_q} + 17'd1;

  assign tab_raddr = AW'(x_q);
  assign stk_raddr = AW'(fill_q - (AW+1)'(1));

  // Sequencer
  always_comb begin
    state_d    = state_q;
    rst_pend_d = 1'b0;
    acc_d      = acc_q;
    bfill_d    = bfill_q;
    next_d     = next_q;
    vend_d     = vend_q;
    cwid_d     = cwid_q;
    wlim_d     = wlim_q;
    prev_d     = prev_q;
    prev_ok_d  = prev_ok_q;
    c_d        = c_q;
    x_d        = x_q;
    grew_d     = grew_q;
    spec_d     = spec_q;
    sub_d      = sub_q;
    pix_d      = pix_q;
    col_d      = col_q;
    fin_d      = fin_q;
    err_d      = err_q;
    fill_d     = fill_q;
    cmd_d      = cmd_q;
    res_d      = res_q;
    tab_we     = 1'b0;
    tab_waddr  = AW'(e_code);
    pre_wdata  = prev_q;
    suf_wdata  = x_q[7:0];
    stk_we     = 1'b0;
    stk_waddr  = AW'(fill_q);
    stk_wdata  = x_q[7:0];
    out_d      = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;

    if (rst_pend_q) begin
      // Reinitialize decoder state
      state_d   = S_IDLE;
      acc_d     = '0;
      bfill_d   = '0;
      sub_d     = '0;
      pix_d     = '0;
      col_d     = '0;
      fin_d     = FIN_RUN;
      err_d     = ST_PIXEL;
      fill_d    = '0;
      next_d    = NCW'(clr) + NCW'(2);
      vend_d    = NCW'(clr) + NCW'(2);
      cwid_d    = mcs + 4'd1;
      wlim_d    = (CW+1)'(1) << (mcs + 4'd1);
      prev_ok_d = 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_d   = in_data_i;
            state_d = S_EXEC;
          end
        end

        S_EXEC: begin
          res_d   = '0;
          state_d = S_FINISH;
          if (fin_q == FIN_DONE) begin
            res_d.status = ST_AFTER_DONE;
          end else if (fin_q == FIN_ERR) begin
            res_d.status = err_q;
          end else if (cmd_q.opcode == OP_PUSH) begin
            // Strip sub-block framing, pack data bits LSB first
            if (fin_q == FIN_TERM) begin
              res_d.status = ST_BYTE_REFUSE;
            end else if (sub_q == 8'd0) begin
              if (cmd_q.stream_byte == 8'd0) begin
                fin_d = FIN_TERM;
              end else begin
                sub_d = cmd_q.stream_byte;
              end
              res_d.status = ST_BYTE_TAKEN;
            end else if (bfill_q > 6'd24) begin
              res_d.status = ST_BYTE_REFUSE;
            end else begin
              acc_d        = acc_q | ({24'd0, cmd_q.stream_byte} << bfill_q);
              bfill_d      = bfill_q + 6'd8;
              sub_d        = sub_q - 8'd1;
              res_d.status = ST_BYTE_TAKEN;
            end
          end else if (fill_q != '0) begin
            // Pop a stacked pixel
            if (pix_q >= total_q) begin
              fin_d        = FIN_ERR;
              err_d        = ST_BAD_CODE;
              res_d.status = ST_BAD_CODE;
            end else begin
              state_d = S_POP;
            end
          end else if (bfill_q < {2'd0, cwid_q}) begin
            if (fin_q == FIN_TERM) begin
              fin_d        = FIN_ERR;
              err_d        = ST_EMPTY_SUB;
              res_d.status = ST_EMPTY_SUB;
            end else begin
              res_d.status = ST_NEED_BYTE;
            end
          end else begin
            // Take one code and advance the dictionary counters
            c_d     = code;
            acc_d   = acc_q >> cwid_q;
            bfill_d = bfill_q - {2'd0, cwid_q};
            grew_d  = 1'b0;
            if (next_q < NCW'(TABLE_DEPTH + 1)) begin
              next_d = next_q + NCW'(1);
              grew_d = 1'b1;
              if ((next_d > NCW'(wlim_q) || wlim_q > (CW+1)'(TABLE_DEPTH)) &&
                  cwid_q < 4'(MAX_CODE_BITS) && ({1'b0, next_d} > (NCW+1)'(wlim_q))) begin
                wlim_d = wlim_q << 1;
                cwid_d = cwid_q + 4'd1;
              end
            end
            if ({1'b0, code} == (CW+1)'(clr) + (CW+1)'(1)) begin
              if (pix_q != total_q) begin
                fin_d        = FIN_ERR;
                err_d        = ST_EARLY_END;
                res_d.status = ST_EARLY_END;
              end else begin
                fin_d        = FIN_DONE;
                res_d.status = ST_DONE;
              end
            end else if ({1'b0, code} == (CW+1)'(clr)) begin
              // Clear: reset dictionary and widths, keep decoding
              next_d    = NCW'(clr) + NCW'(2);
              vend_d    = NCW'(clr) + NCW'(2);
              cwid_d    = mcs + 4'd1;
              wlim_d    = (CW+1)'(1) << (mcs + 4'd1);
              prev_ok_d = 1'b0;
              state_d   = S_EXEC;
            end else begin
              state_d = S_EXPAND;
            end
          end
        end

        S_EXPAND: begin
          // Pick chain root, handle the code-equals-new-entry case
          spec_d  = 1'b0;
          state_d = S_TRACE;
          if ({1'b0, c_q} < (CW+1)'(clr) || c_valid) begin
            x_d = c_q;
          end else if (NCW'(c_q) == e_code && ({1'b0, c_q} < (CW+1)'(TABLE_DEPTH)) &&
                       grew_q && prev_ok_q) begin
            spec_d    = 1'b1;
            x_d       = prev_q;
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = 8'd0;
            fill_d    = (AW+1)'(1);
          end else begin
            fin_d        = FIN_ERR;
            err_d        = ST_BAD_CODE;
            res_d        = '0;
            res_d.status = ST_BAD_CODE;
            state_d      = S_FINISH;
          end
        end

        S_TRACE: begin
          if ({1'b0, x_q} < (CW+1)'(clr)) begin
            // Root reached: push it and add the new entry
            stk_we = 1'b1;
            fill_d = fill_q + (AW+1)'(1);
            if (grew_q && prev_ok_q) begin
              tab_we = 1'b1;
              vend_d = e_code + NCW'(1);
            end
            prev_d    = c_q;
            prev_ok_d = 1'b1;
            state_d   = spec_q ? S_FIX : S_EXEC;
          end else if (!x_valid) begin
            fin_d        = FIN_ERR;
            err_d        = ST_BAD_CODE;
            res_d        = '0;
            res_d.status = ST_BAD_CODE;
            state_d      = S_FINISH;
          end else if (fill_q >= (AW+1)'(TABLE_DEPTH - 1)) begin
            fin_d        = FIN_ERR;
            err_d        = ST_CHAIN_LONG;
            res_d        = '0;
            res_d.status = ST_CHAIN_LONG;
            state_d      = S_FINISH;
          end else begin
            state_d = S_TRACE_WB;
          end
        end

        S_TRACE_WB: begin
          // Push suffix, follow prefix
          stk_we    = 1'b1;
          stk_wdata = suf_rdata;
          fill_d    = fill_q + (AW+1)'(1);
          x_d       = pre_rdata;
          state_d   = S_TRACE;
        end

        S_FIX: begin
          // First pixel of the new entry equals its root
          stk_we    = 1'b1;
          stk_waddr = '0;
          state_d   = S_EXEC;
        end

        S_POP: begin
          fill_d             = fill_q - (AW+1)'(1);
          pix_d              = pix_q + 32'd1;
          res_d              = '0;
          res_d.status       = ST_PIXEL;
          res_d.pixel_index  = stk_rdata;
          res_d.end_of_line  = (col_inc >= {1'b0, lw_eff});
          res_d.end_of_image = (pix_d == total_q);
          col_d              = res_d.end_of_line ? 16'd0 : col_inc[15:0];
          state_d            = S_FINISH;
        end

        S_FINISH: begin
          // Hand the result to the output register once it is free
          if (!out_valid_q || out_ready_i) begin
            out_d       = res_q;
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
          end
        end

        default: state_d = S_IDLE;
      endcase
    end

    if (cfg_we_i && (cfg_idx_i == REG_MIN_CODE_SIZE || cfg_idx_i == REG_LINE_WIDTH ||
                     cfg_idx_i == REG_LINE_COUNT)) begin
      rst_pend_d = 1'b1;
    end
  end

  // Configuration registers and product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcs_q   <= 4'd8;
      lw_q    <= 16'd1;
      lc_q    <= 16'd1;
      total_q <= 32'd1;
    end else begin
      total_q <= {16'd0, lw_eff} * {16'd0, lc_eff};
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MIN_CODE_SIZE: mcs_q <= cfg_data_i[3:0];
          REG_LINE_WIDTH:    lw_q  <= cfg_data_i;
          REG_LINE_COUNT:    lc_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rst_pend_q  <= 1'b1;
      out_valid_q <= 1'b0;
      fin_q       <= FIN_RUN;
      err_q       <= ST_PIXEL;
      fill_q      <= '0;
      bfill_q     <= '0;
      sub_q       <= '0;
      pix_q       <= '0;
      col_q       <= '0;
      prev_ok_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      rst_pend_q  <= rst_pend_d;
      out_valid_q <= out_valid_d;
      fin_q       <= fin_d;
      err_q       <= err_d;
      fill_q      <= fill_d;
      bfill_q     <= bfill_d;
      sub_q       <= sub_d;
      pix_q       <= pix_d;
      col_q       <= col_d;
      prev_ok_q   <= prev_ok_d;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    next_q <= next_d;
    vend_q <= vend_d;
    cwid_q <= cwid_d;
    wlim_q <= wlim_d;
    prev_q <= prev_d;
    c_q    <= c_d;
    x_q    <= x_d;
    grew_q <= grew_d;
    spec_q <= spec_d;
    cmd_q  <= cmd_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE) && !rst_pend_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  glzw_ram #(.Width(CW), .Depth(TABLE_DEPTH)) u_prefix (
    .clk_i, .we_i(tab_we), .waddr_i(tab_waddr), .wdata_i(pre_wdata),
    .raddr_i(tab_raddr), .rdata_o(pre_rdata)
  );

  glzw_ram #(.Width(8), .Depth(TABLE_DEPTH)) u_suffix (
    .clk_i, .we_i(tab_we), .waddr_i(tab_waddr), .wdata_i(suf_wdata),
    .raddr_i(tab_raddr), .rdata_o(suf_rdata)
  );

  glzw_ram #(.Width(8), .Depth(TABLE_DEPTH)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );

endmodule

FILE: rtl/glzw_chk.sv
// Port-level checker for the GIF LZW pixel decoder, bound to the top level.
// Depends on glzw_pkg.
module glzw_chk import glzw_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // A waiting result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // The sequencer does not take a second transaction back to back
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction taken back to back");

  // Non-pixel results carry zero fields
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_PIXEL |->
      out_data_o.pixel_index == 8'd0 && !out_data_o.end_of_line &&
      !out_data_o.end_of_image)
    else $error("stray payload on status result");

  // Last pixel of the image closes a line
  a_eoi_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.end_of_image |-> out_data_o.end_of_line)
    else $error("image ended mid-line");

endmodule

bind gif_lzw_pixel_decoder_top glzw_chk u_glzw_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
);
